// ===== design/vpwre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpwre_pkg
// Shared types and constants for the VGA planar write/read engine.
// ----------------------------------------------------------------------------
package vpwre_pkg;

	localparam int ADDR_W        = 17;
	localparam int DATA_W        = 8;
	localparam int PIX_PER_WORD  = 8;
	localparam int PIX_W         = 4;
	localparam int WORD_W        = PIX_PER_WORD * PIX_W;
	localparam int MEM_WORDS_DEF = 65536;
	localparam int CFG_IDX_W     = 3;

	// command queue between front and back (power of two)
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam logic [DATA_W-1:0] OOR_READ_DATA = 8'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WRITE_CONTROL      = 3'd0,
		REG_READ_CONTROL       = 3'd1,
		REG_SET_RESET_COLOR    = 3'd2,
		REG_SET_RESET_ENABLE   = 3'd3,
		REG_COMPARE_COLOR      = 3'd4,
		REG_COMPARE_CARE_MASK  = 3'd5,
		REG_PIXEL_BIT_MASK     = 3'd6,
		REG_PLANE_WRITE_ENABLE = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WMODE_SET_RESET   = 2'd0,
		WMODE_LATCH       = 2'd1,
		WMODE_DIRECT      = 2'd2,
		WMODE_MASKED_FILL = 2'd3
	} wmode_t;

	typedef enum logic [1:0] {
		LOP_NONE = 2'd0,
		LOP_AND  = 2'd1,
		LOP_OR   = 2'd2,
		LOP_XOR  = 2'd3
	} lop_t;

	typedef enum logic {
		RMODE_PLANE   = 1'b0,
		RMODE_COMPARE = 1'b1
	} rmode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS
	} state_t;

	typedef struct packed {
		logic [6:0]        write_control;
		logic [2:0]        read_control;
		logic [PIX_W-1:0]  set_reset_color;
		logic [PIX_W-1:0]  set_reset_enable;
		logic [PIX_W-1:0]  compare_color;
		logic [PIX_W-1:0]  compare_care_mask;
		logic [DATA_W-1:0] pixel_bit_mask;
		logic [PIX_W-1:0]  plane_write_enable;
	} cfg_t;

	typedef struct packed {
		logic              write;
		logic              in_range;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/vpwre_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpwre_front
// Host side: takes accesses, range-checks them, queues commands for the back.
// ----------------------------------------------------------------------------
module vpwre_front
	import vpwre_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              kind,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [DATA_W-1:0] write_data,
	input  wire logic              clearing,
	output cmd_t                   cmd,
	output logic                   cmd_empty,
	input  wire logic              cmd_pop
);

	cmd_t                 fifo_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 accept;
	cmd_t                 new_cmd;

	assign full      = clearing || (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign accept    = push && !full;
	assign cmd_empty = (count_q == '0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_comb begin
		new_cmd.write    = kind;
		new_cmd.in_range = ({1'b0, address} < (ADDR_W + 1)'(MEM_WORDS));
		new_cmd.address  = address;
		new_cmd.data     = write_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({accept, cmd_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/vpwre_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpwre_back
// Memory side: clear sweep, read-modify-write against the pixel memory,
// pixel latch, read modes and write modes.
// ----------------------------------------------------------------------------
module vpwre_back
	import vpwre_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire cmd_t              cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	input  wire logic              out_free,
	output logic                   res_push,
	output logic [DATA_W-1:0]      res_data,
	output logic                   clearing
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [WORD_W-1:0] mem [MEM_WORDS];

	state_t            state_q;
	state_t            state_d;
	cmd_t              cmd_q;
	logic [WORD_W-1:0] latch_q;
	logic [WORD_W-1:0] rdata_q;
	logic [AW-1:0]     clr_cnt_q;
	logic              clr_last;
	logic              go;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic              latch_ld;
	logic [WORD_W-1:0] new_word;
	logic [DATA_W-1:0] rd_byte;

	function automatic logic [PIX_W-1:0] lop_apply(input logic [1:0] op,
			input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] l);
		logic [PIX_W-1:0] r;
		case (lop_t'(op))
			LOP_AND: r = x & l;
			LOP_OR:  r = x | l;
			LOP_XOR: r = x ^ l;
			default: r = x;
		endcase
		return r;
	endfunction

	assign clr_last = (clr_cnt_q == AW'(MEM_WORDS - 1));
	assign go       = !cmd_empty && (cmd.write || out_free);
	assign clearing = (state_q == ST_CLEAR);

	// write data path: new pixels from host byte, set/reset, latch, mask
	always_comb begin
		logic [2*DATA_W-1:0] rot2;
		logic [DATA_W-1:0]   rd;
		logic [PIX_W-1:0]    l;
		logic [PIX_W-1:0]    x;
		logic [PIX_W-1:0]    x0;
		logic                hb;
		logic                mk;
		rot2 = {cmd_q.data, cmd_q.data} >> cfg.write_control[4:2];
		rd   = rot2[DATA_W-1:0];
		for (int i = 0; i < PIX_PER_WORD; i++) begin
			hb = rd[PIX_PER_WORD-1-i];
			mk = cfg.pixel_bit_mask[PIX_PER_WORD-1-i];
			l  = latch_q[PIX_W*i +: PIX_W];
			x0 = cmd_q.data[PIX_W-1:0];
			case (wmode_t'(cfg.write_control[1:0]))
				WMODE_LATCH:       x = l;
				WMODE_MASKED_FILL: x = (hb && mk) ? cfg.set_reset_color : l;
				WMODE_SET_RESET: begin
					x0 = ({PIX_W{hb}} & ~cfg.set_reset_enable)
						| (cfg.set_reset_color & cfg.set_reset_enable);
					x  = mk ? lop_apply(cfg.write_control[6:5], x0, l) : l;
				end
				default: x = mk ? lop_apply(cfg.write_control[6:5], x0, l) : l;
			endcase
			new_word[PIX_W*i +: PIX_W] = (rdata_q[PIX_W*i +: PIX_W] & ~cfg.plane_write_enable)
				| (x & cfg.plane_write_enable);
		end
	end

	// read data path: plane select or color compare on the fresh word
	always_comb begin
		logic [PIX_W-1:0] p;
		for (int i = 0; i < PIX_PER_WORD; i++) begin
			p = rdata_q[PIX_W*i +: PIX_W];
			if (rmode_t'(cfg.read_control[0]) == RMODE_PLANE) begin
				rd_byte[PIX_PER_WORD-1-i] = p[cfg.read_control[2:1]];
			end else begin
				rd_byte[PIX_PER_WORD-1-i] = ((p & cfg.compare_care_mask)
					== (cfg.compare_color & cfg.compare_care_mask));
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (go && cmd.in_range) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cmd_q.address[AW-1:0];
		mem_wdata = new_word;
		res_push  = 1'b0;
		res_data  = rd_byte;
		latch_ld  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (go) begin
					cmd_pop = 1'b1;
					if (cmd.in_range) begin
						mem_re = 1'b1;
					end else if (!cmd.write) begin
						res_push = 1'b1;
						res_data = OOR_READ_DATA;
					end
				end
			end
			ST_ACCESS: begin
				if (cmd_q.write) begin
					mem_we = 1'b1;
				end else begin
					res_push = 1'b1;
					latch_ld = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[cmd.address[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			latch_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (latch_ld) begin
				latch_q <= rdata_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_access_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACCESS |-> $past(state_q) == ST_IDLE)
		else $error("access without a preceding issue");

	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !cmd_pop && !res_push && !mem_re)
		else $error("transaction during clear sweep");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> out_free)
		else $error("result pushed into busy output register");

	a_access_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACCESS |-> cmd_q.in_range)
		else $error("out-of-range command reached memory");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("pop from empty command queue");
`endif

endmodule
`default_nettype wire

// ===== design/vga_planar_write_read_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vga_planar_write_read_engine_core
// VGA 16-color planar memory engine: graphics controller read/write modes
// against a word-per-eight-pixels memory, with a pixel latch.
// ----------------------------------------------------------------------------
//
//   channel   handshake                fields                         dir
//   -------   ----------------------   ----------------------------   ---
//   access    push / full              kind, address, write_data      in
//   result    pop / empty              read_data                      out
//   config    cfg_we (no wait)         cfg_index, cfg_data            in
//
// In-range read or write: the back end does a memory read, then the
// latch update or memory write-back, set by the single memory port with its
// registered read. Out-of-range accesses skip the memory. Accesses queue up to
// CMD_DEPTH deep in front, so push keeps going while a result waits on pop.
// After reset the memory is swept to zero; full is high during the sweep.
// Config writes land immediately, in any cycle.
//
module vga_planar_write_read_engine_core
	import vpwre_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// access queue side
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 kind,
	input  wire logic [ADDR_W-1:0]    address,
	input  wire logic [DATA_W-1:0]    write_data,
	// result queue side
	output logic                      empty,
	input  wire logic                 pop,
	output logic [DATA_W-1:0]         read_data,
	// register writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	cfg_t              cfg_q;
	cmd_t              cmd;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              clearing;
	logic              out_free;
	logic              res_push;
	logic [DATA_W-1:0] res_data;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	// Register file; each value keeps only its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_control      <= '0;
			cfg_q.read_control       <= '0;
			cfg_q.set_reset_color    <= '0;
			cfg_q.set_reset_enable   <= '0;
			cfg_q.compare_color      <= '0;
			cfg_q.compare_care_mask  <= '1;
			cfg_q.pixel_bit_mask     <= '1;
			cfg_q.plane_write_enable <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WRITE_CONTROL:      cfg_q.write_control      <= cfg_data[6:0];
				REG_READ_CONTROL:       cfg_q.read_control       <= cfg_data[2:0];
				REG_SET_RESET_COLOR:    cfg_q.set_reset_color    <= cfg_data[PIX_W-1:0];
				REG_SET_RESET_ENABLE:   cfg_q.set_reset_enable   <= cfg_data[PIX_W-1:0];
				REG_COMPARE_COLOR:      cfg_q.compare_color      <= cfg_data[PIX_W-1:0];
				REG_COMPARE_CARE_MASK:  cfg_q.compare_care_mask  <= cfg_data[PIX_W-1:0];
				REG_PIXEL_BIT_MASK:     cfg_q.pixel_bit_mask     <= cfg_data;
				REG_PLANE_WRITE_ENABLE: cfg_q.plane_write_enable <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: range check and command queue.
	vpwre_front #(
		.MEM_WORDS (MEM_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.address    (address),
		.write_data (write_data),
		.clearing   (clearing),
		.cmd        (cmd),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop)
	);

	// Back: memory, latch, read/write modes.
	vpwre_back #(
		.MEM_WORDS (MEM_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_free  (out_free),
		.res_push  (res_push),
		.res_data  (res_data),
		.clearing  (clearing)
	);

	// Output register: one result slot; a pop frees it in the same cycle.
	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign read_data = out_data_q;

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_data_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
